FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that an antecedent is followed by a consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/kfmm_pkg.sv
package kfmm_pkg;

   localparam int TABLE_SLOTS = 64;
   localparam int KEY_BITS    = 32;
   localparam int COUNT_BITS  = 32;
   localparam int WORD_BITS   = 32;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

   typedef enum logic {
      CMD_INC = 1'b0,
      CMD_DEC = 1'b1
   } kfmm_cmd_type;

   typedef struct packed {
      kfmm_cmd_type         cmd;
      logic [WORD_BITS-1:0] key;
   } kfmm_req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] max_key;
      logic [WORD_BITS-1:0] min_key;
      logic                 is_empty;
      logic                 table_full;
   } kfmm_rsp_type;

   typedef struct packed {
      kfmm_cmd_type        cmd;
      logic [KEY_BITS-1:0] key;
   } kfmm_bcast_type;

   typedef struct packed {
      logic                  active;
      logic                  insert;
      logic                  any;
      logic [COUNT_BITS-1:0] max_count;
      logic [KEY_BITS-1:0]   max_key;
      logic [COUNT_BITS-1:0] min_count;
      logic [KEY_BITS-1:0]   min_key;
   } kfmm_wave_type;

endpackage

FILE: rtl/kfmm_cell.sv
module kfmm_cell
   import kfmm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  kfmm_bcast_type bcast,
   input  kfmm_wave_type  wave_in,
   output kfmm_wave_type  wave_out,
   output logic           hit
);

   logic                  valid_ff, valid_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  hit_ff;
   kfmm_wave_type         wave_ff, wave_in_next;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      count_in = count_ff;
      wave_in_next = wave_in;
      if (hit_ff) begin
         unique case (bcast.cmd)
            CMD_INC: begin
               if (count_ff != COUNT_MAX) begin
                  count_in = count_ff + COUNT_ONE;
               end
            end
            CMD_DEC: begin
               if (count_ff <= COUNT_ONE) begin
                  valid_in = 1'b0;
                  count_in = '0;
               end else begin
                  count_in = count_ff - COUNT_ONE;
               end
            end
            default: begin
               valid_in = valid_ff;
            end
         endcase
      end else if (wave_in.insert && !valid_ff) begin
         valid_in = 1'b1;
         key_in   = bcast.key;
         count_in = COUNT_ONE;
         wave_in_next.insert = 1'b0;
      end
      if (valid_in) begin
         if (!wave_in.any || count_in > wave_in.max_count) begin
            wave_in_next.max_count = count_in;
            wave_in_next.max_key   = key_in;
         end
         if (!wave_in.any || count_in < wave_in.min_count) begin
            wave_in_next.min_count = count_in;
            wave_in_next.min_key   = key_in;
         end
         wave_in_next.any = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= 1'b0;
         count_ff       <= '0;
         hit_ff         <= 1'b0;
         wave_ff.active <= 1'b0;
      end else begin
         hit_ff  <= valid_ff && (key_ff == bcast.key);
         wave_ff <= wave_in_next;
         if (wave_in.active) begin
            valid_ff <= valid_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wave_in.active) begin
         key_ff <= key_in;
      end
   end

   assign wave_out = wave_ff;
   assign hit      = hit_ff;

endmodule

FILE: rtl/key_frequency_max_min_tracker.sv
// Flow: an accepted word passes the match and launch states, then the update wave runs through all
// TABLE_SLOTS cells, stepping one cell a cycle; a new word is taken only once the result has strobed.
// busy is high from acceptance until the result strobe; results cannot be stalled.
// Reset (synchronous, active high) empties the table and leaves the block idle.
`include "assert_macros.svh"

module key_frequency_max_min_tracker
   import kfmm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  kfmm_req_type req_word,
   output logic         rsp_strobe,
   output kfmm_rsp_type rsp_word
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_LAUNCH,
      ST_RUN
   } state_type;

   state_type        state_ff;
   kfmm_bcast_type   bcast_ff;
   logic             rsp_strobe_ff;
   kfmm_rsp_type     rsp_ff;
   kfmm_wave_type    wave [TABLE_SLOTS+1];
   kfmm_wave_type    head;
   logic [TABLE_SLOTS-1:0] hit_vec;
   logic             accept;
   kfmm_wave_type    last;

   assign accept = start && (state_ff == ST_IDLE);
   assign last   = wave[TABLE_SLOTS];

   always_comb begin
      head        = '0;
      head.active = (state_ff == ST_LAUNCH);
      head.insert = (bcast_ff.cmd == CMD_INC) && !(|hit_vec);
   end

   assign wave[0] = head;

   for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
      kfmm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .bcast    (bcast_ff),
         .wave_in  (wave[i]),
         .wave_out (wave[i+1]),
         .hit      (hit_vec[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  bcast_ff.cmd <= req_word.cmd;
                  bcast_ff.key <= KEY_BITS'(req_word.key);
                  state_ff     <= ST_MATCH;
               end
            end
            ST_MATCH: begin
               state_ff <= ST_LAUNCH;
            end
            ST_LAUNCH: begin
               state_ff <= ST_RUN;
            end
            ST_RUN: begin
               if (last.active) begin
                  rsp_strobe_ff       <= 1'b1;
                  rsp_ff.max_key      <= last.any ? WORD_BITS'(last.max_key) : '0;
                  rsp_ff.min_key      <= last.any ? WORD_BITS'(last.min_key) : '0;
                  rsp_ff.is_empty     <= !last.any;
                  rsp_ff.table_full   <= last.insert;
                  state_ff            <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

   `ASSERT_CLK(a_hit_unique, clock, reset, $onehot0(hit_vec), "key held in more than one slot")
   `ASSERT_CLK(a_wave_end_run, clock, reset, !last.active || (state_ff == ST_RUN),
      "update wave left the chain outside the run state")
   `ASSERT_NEXT(a_accept_match, clock, reset, accept, state_ff == ST_MATCH,
      "accepted word did not start a match")
   `ASSERT_CLK(a_empty_keys, clock, reset,
      !(rsp_strobe_ff && rsp_ff.is_empty) || (rsp_ff.max_key == '0 && rsp_ff.min_key == '0),
      "empty table reported a key")

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
   import kfmm_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = TABLE_SLOTS + 16;
   localparam int POOL_KEYS      = 96;
   localparam int HOT_KEYS       = 8;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   kfmm_req_type req_word = '0;
   logic         rsp_strobe;
   kfmm_rsp_type rsp_word;

   logic                  tally_valid [TABLE_SLOTS];
   logic [KEY_BITS-1:0]   tally_key   [TABLE_SLOTS];
   logic [COUNT_BITS-1:0] tally_count [TABLE_SLOTS];

   kfmm_rsp_type pending_summary [$];
   kfmm_rsp_type want;
   int           fail_count = 0;
   int           quiet_cycles = 0;
   int           idle_pct = 0;

   key_frequency_max_min_tracker u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic kfmm_rsp_type update_tally(kfmm_req_type w);
      logic [KEY_BITS-1:0] k;
      int                  s;
      int                  hit;
      int                  spare;
      int                  hi;
      int                  lo;
      kfmm_rsp_type        r;
      k     = KEY_BITS'(w.key);
      hit   = -1;
      spare = -1;
      hi    = -1;
      lo    = -1;
      r     = '0;
      for (s = 0; s < TABLE_SLOTS; s++) begin
         if (tally_valid[s] && tally_key[s] == k && hit < 0)
            hit = s;
         if (!tally_valid[s] && spare < 0)
            spare = s;
      end
      if (w.cmd == CMD_INC) begin
         if (hit >= 0) begin
            if (tally_count[hit] != COUNT_MAX)
               tally_count[hit] = tally_count[hit] + COUNT_ONE;
         end else if (spare < 0) begin
            r.table_full = 1'b1;
         end else begin
            tally_valid[spare] = 1'b1;
            tally_key[spare]   = k;
            tally_count[spare] = COUNT_ONE;
         end
      end else if (hit >= 0) begin
         if (tally_count[hit] <= COUNT_ONE) begin
            tally_valid[hit] = 1'b0;
            tally_count[hit] = '0;
         end else begin
            tally_count[hit] = tally_count[hit] - COUNT_ONE;
         end
      end
      for (s = 0; s < TABLE_SLOTS; s++) begin
         if (tally_valid[s]) begin
            if (hi < 0 || tally_count[s] > tally_count[hi])
               hi = s;
            if (lo < 0 || tally_count[s] < tally_count[lo])
               lo = s;
         end
      end
      r.max_key  = (hi >= 0) ? WORD_BITS'(tally_key[hi]) : '0;
      r.min_key  = (lo >= 0) ? WORD_BITS'(tally_key[lo]) : '0;
      r.is_empty = (hi < 0);
      return r;
   endfunction

   task automatic check_field(input string name, input logic [WORD_BITS-1:0] exp_val,
                              input logic [WORD_BITS-1:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s mismatch: expected %h, got %h", name, exp_val, act_val);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_summary.size() == 0) begin
            $error("result with no word outstanding: max_key %h min_key %h",
                   rsp_word.max_key, rsp_word.min_key);
            fail_count++;
         end else begin
            want = pending_summary.pop_front();
            check_field("max_key", want.max_key, rsp_word.max_key);
            check_field("min_key", want.min_key, rsp_word.min_key);
            check_field("is_empty", WORD_BITS'(want.is_empty), WORD_BITS'(rsp_word.is_empty));
            check_field("table_full", WORD_BITS'(want.table_full),
                        WORD_BITS'(rsp_word.table_full));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_word(input kfmm_cmd_type c, input logic [WORD_BITS-1:0] k);
      kfmm_req_type w;
      w.cmd = c;
      w.key = k;
      if ($urandom_range(99) < idle_pct) begin
         repeat ($urandom_range(1, 90)) begin
            @(negedge clock);
            start = 1'b0;
         end
      end
      @(negedge clock);
      start    = 1'b1;
      req_word = w;
      do @(posedge clock); while (busy);
      pending_summary = {pending_summary, update_tally(w)};
   endtask

   task automatic wait_for_summaries();
      @(negedge clock);
      start = 1'b0;
      while (pending_summary.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_empty_table();
      send_word(CMD_DEC, 32'h0000_0000);
      send_word(CMD_DEC, 32'hFFFF_FFFF);
      wait_for_summaries();
   endtask

   task automatic test_key_extremes();
      send_word(CMD_INC, 32'h0000_0000);
      send_word(CMD_INC, 32'hFFFF_FFFF);
      send_word(CMD_INC, 32'hFFFF_FFFF);
      send_word(CMD_INC, 32'h0000_0000);
      send_word(CMD_DEC, 32'h0000_0000);
      send_word(CMD_DEC, 32'h0000_0000);
      send_word(CMD_DEC, 32'hFFFF_FFFF);
      send_word(CMD_DEC, 32'hFFFF_FFFF);
      send_word(CMD_DEC, 32'hFFFF_FFFF);
      send_word(CMD_INC, 32'h5555_5555);
      send_word(CMD_INC, 32'hAAAA_AAAA);
      send_word(CMD_DEC, 32'h5555_5555);
      send_word(CMD_INC, 32'h1234_5678);
      send_word(CMD_INC, 32'hAAAA_AAAA);
      send_word(CMD_DEC, 32'h1234_5678);
      send_word(CMD_DEC, 32'hAAAA_AAAA);
      send_word(CMD_DEC, 32'hAAAA_AAAA);
      wait_for_summaries();
   endtask

   task automatic test_table_full();
      logic [WORD_BITS-1:0] held [TABLE_SLOTS];
      logic [WORD_BITS-1:0] extra;
      int                   s;
      for (s = 0; s < TABLE_SLOTS; s++) begin
         held[s] = {s[7:0], 24'($urandom)};
         send_word(CMD_INC, held[s]);
      end
      send_word(CMD_INC, {8'hFF, 24'($urandom)});
      send_word(CMD_INC, {8'hFF, 24'($urandom)});
      send_word(CMD_INC, held[5]);
      send_word(CMD_DEC, {8'hFF, 24'($urandom)});
      send_word(CMD_DEC, held[10]);
      extra = {8'hFE, 24'($urandom)};
      send_word(CMD_INC, extra);
      send_word(CMD_INC, {8'hFD, 24'($urandom)});
      send_word(CMD_DEC, extra);
      for (s = 0; s < TABLE_SLOTS; s++)
         send_word(CMD_DEC, held[s]);
      wait_for_summaries();
   endtask

   task automatic test_random_traffic(input int count, input int pct);
      logic [WORD_BITS-1:0] pool [POOL_KEYS];
      logic [WORD_BITS-1:0] k;
      kfmm_cmd_type         c;
      int                   i;
      idle_pct = pct;
      for (i = 0; i < POOL_KEYS; i++)
         pool[i] = $urandom;
      for (i = 0; i < count; i++) begin
         if ($urandom_range(99) < 15) begin
            k = $urandom;
            c = $urandom_range(1) ? CMD_DEC : CMD_INC;
         end else begin
            k = $urandom_range(1) ? pool[$urandom_range(HOT_KEYS - 1)]
                                  : pool[$urandom_range(POOL_KEYS - 1)];
            c = ($urandom_range(99) < 60) ? CMD_INC : CMD_DEC;
         end
         send_word(c, k);
         if (i == count / 2)
            wait_for_summaries();
      end
      wait_for_summaries();
   endtask

   initial begin
      for (int s = 0; s < TABLE_SLOTS; s++) begin
         tally_valid[s] = 1'b0;
         tally_key[s]   = '0;
         tally_count[s] = '0;
      end
      repeat (10) @(negedge clock);
      reset = 1'b0;
      test_empty_table();
      test_key_extremes();
      test_table_full();
      test_random_traffic(500, 0);
      test_random_traffic(500, 45);
      test_random_traffic(500, 15);
      wait_for_summaries();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/kfmm_pkg.sv
rtl/kfmm_cell.sv
rtl/key_frequency_max_min_tracker.sv
tb/sv/tb.sv
